>>> hdl/bbo_pkg.sv
package bbo_pkg;

    localparam int EXCH_COUNT = 32;
    localparam int EXCH_W     = 5;
    localparam int CNT_W      = 6;
    localparam int PRICE_W    = 32;
    localparam int QTY_W      = 32;
    localparam int COND_W     = 8;

    localparam int S_TDATA_W  = 144;
    localparam int M_TDATA_W  = 160;

    localparam logic [2:0] CMD_NONE  = 3'd0;
    localparam logic [2:0] CMD_LOAD  = 3'd1;
    localparam logic [2:0] CMD_OFFER = 3'd2;
    localparam logic [2:0] CMD_START = 3'd3;
    localparam logic [2:0] CMD_CLEAR = 3'd4;

    typedef struct packed {
        logic [PRICE_W-1:0] bid;
        logic [PRICE_W-1:0] ask;
        logic [QTY_W-1:0]   bid_qty;
        logic [QTY_W-1:0]   ask_qty;
        logic [COND_W-1:0]  cond;
    } quote_rec_t;

    typedef struct packed {
        logic [2:0]         op;
        logic [EXCH_W-1:0]  idx;
        logic [PRICE_W-1:0] price;
        logic [QTY_W-1:0]   qty;
        logic [COND_W-1:0]  cond;
    } side_cmd_t;

    typedef struct packed {
        logic [EXCH_W-1:0]  slot;
        logic [PRICE_W-1:0] price;
        logic [QTY_W-1:0]   qty;
        logic [COND_W-1:0]  cond;
        logic               worse;
    } side_stat_t;

endpackage

>>> hdl/bbo_quote_ram.sv
module bbo_quote_ram
    import bbo_pkg::*;
(
    input  logic              aclk,
    input  logic              we,
    input  logic [EXCH_W-1:0] waddr,
    input  quote_rec_t        wdata,
    input  logic [EXCH_W-1:0] raddr,
    output quote_rec_t        rdata
);

    quote_rec_t mem [EXCH_COUNT];
    quote_rec_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> hdl/bbo_side_unit.sv
module bbo_side_unit
    import bbo_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       is_ask,
    input  side_cmd_t  cmd,
    output side_stat_t stat
);

    logic [EXCH_W-1:0]  slot_reg;
    logic [PRICE_W-1:0] price_reg;
    logic [QTY_W-1:0]   qty_reg;
    logic [COND_W-1:0]  cond_reg;
    logic               have_reg;
    logic               better;
    logic               worse;
    logic               take;

    // one comparator pair serves both incremental updates and the rescan
    assign better = is_ask ? (cmd.price < price_reg) : (cmd.price > price_reg);
    assign worse  = (cmd.idx == slot_reg) &&
                    (is_ask ? (cmd.price > price_reg) : (cmd.price < price_reg));

    always_comb begin
        case (cmd.op)
            CMD_LOAD:  take = 1'b1;
            CMD_OFFER: take = !have_reg || better;
            default:   take = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_reg <= '0;
            have_reg <= 1'b0;
        end else if (take) begin
            slot_reg <= cmd.idx;
            have_reg <= 1'b1;
        end else if (cmd.op == CMD_START) begin
            have_reg <= 1'b0;
        end else if (cmd.op == CMD_CLEAR) begin
            slot_reg <= '0;
            have_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            price_reg <= cmd.price;
            qty_reg   <= cmd.qty;
            cond_reg  <= cmd.cond;
        end
    end

    assign stat.slot  = slot_reg;
    assign stat.price = price_reg;
    assign stat.qty   = qty_reg;
    assign stat.cond  = cond_reg;
    assign stat.worse = worse;

endmodule

>>> hdl/best_bid_offer_tracker.sv
// path: clears and ineligible quotes go from idle to emit, incremental quotes
//   go through the update state, plus the scan state when a best holder worsens
// pacing: one transaction at a time, and a stalled result holds off the next; the
//   rescan reads the quote memory once per exchange through its single read port
// reset: synchronous active-low aresetn empties the book and drops any pending result
module best_bid_offer_tracker
    import bbo_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // exchange, bid_price, ask_price, bid_quantity, ask_quantity, quote_condition
    input  logic [S_TDATA_W-1:0] s_tdata,
    // operation, eligible
    input  logic [1:0]           s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // bid price, bid exchange, bid quantity, bid condition,
    // ask price, ask exchange, ask quantity, ask condition
    output logic [M_TDATA_W-1:0] m_tdata,
    // book_valid
    output logic [0:0]           m_tuser
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_UPD  = 2'd1;
    localparam logic [1:0] ST_SCAN = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0]            state_reg;
    logic [EXCH_COUNT-1:0] present_reg;
    logic                  nonempty_reg;
    logic [EXCH_W-1:0]     in_exch_reg;
    quote_rec_t            in_rec_reg;
    logic                  scan_bid_reg;
    logic                  scan_ask_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic                  rd_vld_reg;
    logic [EXCH_W-1:0]     rd_idx_reg;
    logic                  m_valid_reg;
    logic                  m_book_reg;
    logic [M_TDATA_W-1:0]  m_data_reg;

    logic                  s_fire;
    logic                  s_clear;
    logic                  s_quote;
    logic [EXCH_W-1:0]     s_exch;
    quote_rec_t            s_rec;
    quote_rec_t            rd_rec;
    logic                  scan_issue;
    logic                  scan_hit;
    side_cmd_t             bid_cmd;
    side_cmd_t             ask_cmd;
    side_stat_t            bid_stat;
    side_stat_t            ask_stat;
    logic                  emit_ok;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign s_clear  = s_fire && s_tuser[0];
    assign s_quote  = s_fire && !s_tuser[0] && s_tuser[1];

    assign s_exch        = s_tdata[4:0];
    assign s_rec.bid     = s_tdata[36:5];
    assign s_rec.ask     = s_tdata[68:37];
    assign s_rec.bid_qty = s_tdata[100:69];
    assign s_rec.ask_qty = s_tdata[132:101];
    assign s_rec.cond    = s_tdata[140:133];

    assign scan_issue = (state_reg == ST_SCAN) && (cnt_reg != CNT_W'(EXCH_COUNT));
    assign scan_hit   = rd_vld_reg && present_reg[rd_idx_reg];

    bbo_quote_ram u_ram (
        .aclk  (aclk),
        .we    (s_quote),
        .waddr (s_exch),
        .wdata (s_rec),
        .raddr (cnt_reg[EXCH_W-1:0]),
        .rdata (rd_rec)
    );

    always_comb begin
        bid_cmd = '{op: CMD_NONE, idx: in_exch_reg, price: in_rec_reg.bid,
                    qty: in_rec_reg.bid_qty, cond: in_rec_reg.cond};
        ask_cmd = '{op: CMD_NONE, idx: in_exch_reg, price: in_rec_reg.ask,
                    qty: in_rec_reg.ask_qty, cond: in_rec_reg.cond};
        case (state_reg)
            ST_IDLE: begin
                if (s_clear) begin
                    bid_cmd.op = CMD_CLEAR;
                    ask_cmd.op = CMD_CLEAR;
                end
            end
            ST_UPD: begin
                if (!nonempty_reg) begin
                    bid_cmd.op = CMD_LOAD;
                    ask_cmd.op = CMD_LOAD;
                end else begin
                    if (bid_stat.worse) begin
                        bid_cmd.op = CMD_START;
                    end else if (in_exch_reg == bid_stat.slot) begin
                        bid_cmd.op = CMD_LOAD;
                    end else begin
                        bid_cmd.op = CMD_OFFER;
                    end
                    if (ask_stat.worse) begin
                        ask_cmd.op = CMD_START;
                    end else if (in_exch_reg == ask_stat.slot) begin
                        ask_cmd.op = CMD_LOAD;
                    end else begin
                        ask_cmd.op = CMD_OFFER;
                    end
                end
            end
            ST_SCAN: begin
                bid_cmd = '{op: CMD_NONE, idx: rd_idx_reg, price: rd_rec.bid,
                            qty: rd_rec.bid_qty, cond: rd_rec.cond};
                ask_cmd = '{op: CMD_NONE, idx: rd_idx_reg, price: rd_rec.ask,
                            qty: rd_rec.ask_qty, cond: rd_rec.cond};
                if (scan_hit && scan_bid_reg) begin
                    bid_cmd.op = CMD_OFFER;
                end
                if (scan_hit && scan_ask_reg) begin
                    ask_cmd.op = CMD_OFFER;
                end
            end
            default: begin
            end
        endcase
    end

    bbo_side_unit u_bid (
        .aclk    (aclk),
        .aresetn (aresetn),
        .is_ask  (1'b0),
        .cmd     (bid_cmd),
        .stat    (bid_stat)
    );

    bbo_side_unit u_ask (
        .aclk    (aclk),
        .aresetn (aresetn),
        .is_ask  (1'b1),
        .cmd     (ask_cmd),
        .stat    (ask_stat)
    );

    assign emit_ok = (state_reg == ST_EMIT) && (!m_valid_reg || m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            present_reg  <= '0;
            nonempty_reg <= 1'b0;
            scan_bid_reg <= 1'b0;
            scan_ask_reg <= 1'b0;
            cnt_reg      <= '0;
            rd_vld_reg   <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            rd_vld_reg <= scan_issue;
            if (emit_ok) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_clear) begin
                        present_reg  <= '0;
                        nonempty_reg <= 1'b0;
                        state_reg    <= ST_EMIT;
                    end else if (s_quote) begin
                        present_reg[s_exch] <= 1'b1;
                        state_reg           <= ST_UPD;
                    end else if (s_fire) begin
                        state_reg <= ST_EMIT;
                    end
                end
                ST_UPD: begin
                    nonempty_reg <= 1'b1;
                    cnt_reg      <= '0;
                    scan_bid_reg <= nonempty_reg && bid_stat.worse;
                    scan_ask_reg <= nonempty_reg && ask_stat.worse;
                    if (nonempty_reg && (bid_stat.worse || ask_stat.worse)) begin
                        state_reg <= ST_SCAN;
                    end else begin
                        state_reg <= ST_EMIT;
                    end
                end
                ST_SCAN: begin
                    if (scan_issue) begin
                        cnt_reg <= cnt_reg + CNT_W'(1);
                    end else if (!rd_vld_reg) begin
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (emit_ok) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (scan_issue) begin
            rd_idx_reg <= cnt_reg[EXCH_W-1:0];
        end
        if (state_reg == ST_IDLE && s_fire) begin
            in_exch_reg <= s_exch;
            in_rec_reg  <= s_rec;
        end
        if (emit_ok) begin
            m_book_reg <= nonempty_reg;
            if (nonempty_reg) begin
                m_data_reg <= {6'd0, ask_stat.cond, ask_stat.qty, ask_stat.slot,
                               ask_stat.price, bid_stat.cond, bid_stat.qty,
                               bid_stat.slot, bid_stat.price};
            end else begin
                m_data_reg <= '0;
            end
        end
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_data_reg;
    assign m_tuser[0] = m_book_reg;

endmodule

>>> hdl/bbo_checker.sv
module bbo_port_props
    import bbo_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic [S_TDATA_W-1:0] s_tdata,
    input logic [1:0]           s_tuser,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic [0:0]           m_tuser
);

    // stalled result transaction holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // one input transaction in flight at a time
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while busy");

    // empty book reports all-zero fields
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata == '0)
        else $error("empty book with nonzero fields");

endmodule

bind best_bid_offer_tracker bbo_port_props u_bbo_port_props (.*);

>>> tb/bbo_tb_pkg.sv
`timescale 1ns / 100ps

package bbo_tb_pkg;

    import bbo_pkg::*;

    localparam logic OP_QUOTE = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    localparam int S_PAD_W = S_TDATA_W - (EXCH_W + 2 * PRICE_W + 2 * QTY_W + COND_W);
    localparam int M_PAD_W = M_TDATA_W - 2 * (PRICE_W + EXCH_W + QTY_W + COND_W);

    // input transaction payload, msb first
    typedef struct packed {
        logic [S_PAD_W-1:0] pad;
        logic [COND_W-1:0]  cond;
        logic [QTY_W-1:0]   ask_qty;
        logic [QTY_W-1:0]   bid_qty;
        logic [PRICE_W-1:0] ask;
        logic [PRICE_W-1:0] bid;
        logic [EXCH_W-1:0]  exch;
    } quote_word_t;

    typedef struct packed {
        logic eligible;
        logic operation;
    } quote_flags_t;

    // result transaction payload, msb first
    typedef struct packed {
        logic [M_PAD_W-1:0] pad;
        logic [COND_W-1:0]  ask_cond;
        logic [QTY_W-1:0]   ask_qty;
        logic [EXCH_W-1:0]  ask_exch;
        logic [PRICE_W-1:0] ask_price;
        logic [COND_W-1:0]  bid_cond;
        logic [QTY_W-1:0]   bid_qty;
        logic [EXCH_W-1:0]  bid_exch;
        logic [PRICE_W-1:0] bid_price;
    } book_word_t;

    typedef struct packed {
        logic       live;
        book_word_t tops;
    } book_view_t;

endpackage

>>> tb/bbo_checker.sv
`timescale 1ns / 100ps

module bbo_checker
    import bbo_pkg::*;
    import bbo_tb_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic [1:0]           s_tuser,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,
    input  logic [0:0]           m_tuser,
    output int                   fail_count,
    output int                   pending,
    output int                   checked,
    output int                   rescans
);

    logic               held [EXCH_COUNT];
    logic [PRICE_W-1:0] bid_book [EXCH_COUNT];
    logic [PRICE_W-1:0] ask_book [EXCH_COUNT];
    logic [QTY_W-1:0]   bid_qty_book [EXCH_COUNT];
    logic [QTY_W-1:0]   ask_qty_book [EXCH_COUNT];
    logic [COND_W-1:0]  cond_book [EXCH_COUNT];
    logic [EXCH_W-1:0]  bid_holder;
    logic [EXCH_W-1:0]  ask_holder;
    logic               book_live;

    // at most two results are outstanding at once
    book_view_t         expected_tops [4];
    logic [1:0]         wr_ptr;
    logic [1:0]         rd_ptr;

    task automatic note_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        if (fail_count < 30) begin
            $display("bbo check: result %0d %s got %h want %h", checked, what, got, want);
        end
        fail_count++;
    endtask

    function automatic logic [EXCH_W-1:0] highest_bid_slot();
        logic [EXCH_W-1:0] pick;
        logic              have;
        pick = '0;
        have = 1'b0;
        for (int i = 0; i < EXCH_COUNT; i++) begin
            if (held[i] && (!have || bid_book[i] > bid_book[pick])) begin
                pick = EXCH_W'(i);
                have = 1'b1;
            end
        end
        return pick;
    endfunction

    function automatic logic [EXCH_W-1:0] lowest_ask_slot();
        logic [EXCH_W-1:0] pick;
        logic              have;
        pick = '0;
        have = 1'b0;
        for (int i = 0; i < EXCH_COUNT; i++) begin
            if (held[i] && (!have || ask_book[i] < ask_book[pick])) begin
                pick = EXCH_W'(i);
                have = 1'b1;
            end
        end
        return pick;
    endfunction

    task automatic absorb_quote(input quote_flags_t f, input quote_word_t q);
        logic bid_worse;
        logic ask_worse;
        bid_worse = 1'b0;
        ask_worse = 1'b0;
        if (f.operation == OP_CLEAR) begin
            for (int i = 0; i < EXCH_COUNT; i++) begin
                held[i] = 1'b0;
            end
            bid_holder = '0;
            ask_holder = '0;
            book_live  = 1'b0;
        end else if (f.eligible) begin
            if (held[q.exch] && book_live) begin
                bid_worse = (q.exch == bid_holder) && (q.bid < bid_book[bid_holder]);
                ask_worse = (q.exch == ask_holder) && (q.ask > ask_book[ask_holder]);
            end
            held[q.exch]         = 1'b1;
            bid_book[q.exch]     = q.bid;
            ask_book[q.exch]     = q.ask;
            bid_qty_book[q.exch] = q.bid_qty;
            ask_qty_book[q.exch] = q.ask_qty;
            cond_book[q.exch]    = q.cond;
            if (!book_live) begin
                book_live  = 1'b1;
                bid_holder = q.exch;
                ask_holder = q.exch;
            end else begin
                if (bid_worse) begin
                    bid_holder = highest_bid_slot();
                    rescans++;
                end else if (q.bid > bid_book[bid_holder]) begin
                    bid_holder = q.exch;
                end
                if (ask_worse) begin
                    ask_holder = lowest_ask_slot();
                    rescans++;
                end else if (q.ask < ask_book[ask_holder]) begin
                    ask_holder = q.exch;
                end
            end
        end
    endtask

    function automatic book_view_t top_of_book();
        book_view_t v;
        v = '0;
        if (book_live) begin
            v.live               = 1'b1;
            v.tops.bid_price     = bid_book[bid_holder];
            v.tops.bid_exch      = bid_holder;
            v.tops.bid_qty       = bid_qty_book[bid_holder];
            v.tops.bid_cond      = cond_book[bid_holder];
            v.tops.ask_price     = ask_book[ask_holder];
            v.tops.ask_exch      = ask_holder;
            v.tops.ask_qty       = ask_qty_book[ask_holder];
            v.tops.ask_cond      = cond_book[ask_holder];
        end
        return v;
    endfunction

    always @(posedge aclk) begin
        book_view_t want;
        book_word_t got;
        if (!aresetn) begin
            fail_count = 0;
            pending    = 0;
            checked    = 0;
            rescans    = 0;
            book_live  = 1'b0;
            bid_holder = '0;
            ask_holder = '0;
            wr_ptr     = '0;
            rd_ptr     = '0;
            for (int i = 0; i < EXCH_COUNT; i++) begin
                held[i] = 1'b0;
            end
        end else begin
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                if (pending == 0) begin
                    note_mismatch("unexpected transaction", got.bid_price, '0);
                end else begin
                    want    = expected_tops[rd_ptr];
                    rd_ptr  = rd_ptr + 2'd1;
                    pending = pending - 1;
                    if (m_tuser[0] !== want.live)
                        note_mismatch("book_valid", 32'(m_tuser[0]), 32'(want.live));
                    if (got.bid_price !== want.tops.bid_price)
                        note_mismatch("bid price", got.bid_price, want.tops.bid_price);
                    if (got.bid_exch !== want.tops.bid_exch)
                        note_mismatch("bid exchange", 32'(got.bid_exch),
                                      32'(want.tops.bid_exch));
                    if (got.bid_qty !== want.tops.bid_qty)
                        note_mismatch("bid quantity", got.bid_qty, want.tops.bid_qty);
                    if (got.bid_cond !== want.tops.bid_cond)
                        note_mismatch("bid condition", 32'(got.bid_cond),
                                      32'(want.tops.bid_cond));
                    if (got.ask_price !== want.tops.ask_price)
                        note_mismatch("ask price", got.ask_price, want.tops.ask_price);
                    if (got.ask_exch !== want.tops.ask_exch)
                        note_mismatch("ask exchange", 32'(got.ask_exch),
                                      32'(want.tops.ask_exch));
                    if (got.ask_qty !== want.tops.ask_qty)
                        note_mismatch("ask quantity", got.ask_qty, want.tops.ask_qty);
                    if (got.ask_cond !== want.tops.ask_cond)
                        note_mismatch("ask condition", 32'(got.ask_cond),
                                      32'(want.tops.ask_cond));
                end
                checked++;
            end
            if (s_tvalid && s_tready) begin
                absorb_quote(quote_flags_t'(s_tuser), quote_word_t'(s_tdata));
                expected_tops[wr_ptr] = top_of_book();
                wr_ptr  = wr_ptr + 2'd1;
                pending = pending + 1;
            end
        end
    end

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps

module tb;

    import bbo_pkg::*;
    import bbo_tb_pkg::*;

    localparam int RANDOM_ITEMS = 1250;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 40;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [1:0]           s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [0:0]           m_tuser;

    int  fail_count;
    int  pending;
    int  checked;
    int  rescans;
    int  cycles;
    int  sent;
    int  clears;
    int  ignored;
    logic calm;

    best_bid_offer_tracker u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    bbo_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .fail_count (fail_count),
        .pending    (pending),
        .checked    (checked),
        .rescans    (rescans)
    );

    always #1 aclk = ~aclk;

    always @(negedge aclk) begin
        m_tready <= calm || ($urandom_range(99) >= 18);
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb: errors");
            $finish;
        end
    end

    task automatic drive_item(input logic op, input logic elig, input logic [EXCH_W-1:0] exch,
                              input logic [PRICE_W-1:0] bid, input logic [PRICE_W-1:0] ask,
                              input logic [QTY_W-1:0] bid_qty, input logic [QTY_W-1:0] ask_qty,
                              input logic [COND_W-1:0] cond);
        quote_word_t  w;
        quote_flags_t f;
        w = '{pad: '0, cond: cond, ask_qty: ask_qty, bid_qty: bid_qty,
              ask: ask, bid: bid, exch: exch};
        f = '{eligible: elig, operation: op};
        while (!calm && $urandom_range(99) < 18) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= w;
        s_tuser  <= f;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
        sent++;
        if (op == OP_CLEAR) clears++;
        else if (!elig) ignored++;
    endtask

    task automatic put_quote(input logic [EXCH_W-1:0] exch, input logic [PRICE_W-1:0] bid,
                             input logic [PRICE_W-1:0] ask);
        drive_item(OP_QUOTE, 1'b1, exch, bid, ask, $urandom, $urandom,
                   COND_W'($urandom_range(255)));
    endtask

    task automatic drop_book();
        drive_item(OP_CLEAR, 1'($urandom_range(1)), EXCH_W'($urandom_range(31)), $urandom,
                   $urandom, $urandom, $urandom, COND_W'($urandom_range(255)));
    endtask

    function automatic logic [PRICE_W-1:0] pick_price();
        int r;
        r = $urandom_range(99);
        if (r < 2) return '0;
        if (r < 4) return '1;
        if (r < 6) return 1;
        if (r < 8) return 32'hFFFF_FFFE;
        if (r < 25) return $urandom;
        return 1000 + $urandom_range(12);
    endfunction

    function automatic logic [EXCH_W-1:0] pick_exchange();
        int r;
        r = $urandom_range(99);
        if (r < 50) return EXCH_W'($urandom_range(3));
        if (r < 80) return EXCH_W'($urandom_range(12, 7));
        return EXCH_W'($urandom_range(31));
    endfunction

    initial begin
        int effective;
        int r;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        calm     = 1'b0;
        sent     = 0;
        clears   = 0;
        ignored  = 0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed part
        drop_book();
        drive_item(OP_QUOTE, 1'b0, 31, 500, 600, 7, 8, 8'h11);
        put_quote(5, 100, 200);
        put_quote(9, 150, 180);
        put_quote(2, 150, 180);
        put_quote(9, 90, 250);
        put_quote(7, 150, 180);
        put_quote(12, 150, 180);
        put_quote(2, 10, 300);
        put_quote(7, 150, 180);
        drive_item(OP_QUOTE, 1'b0, 0, 32'hFFFF_FFFF, 0, 1, 1, 8'hA5);
        drive_item(OP_QUOTE, 1'b1, 0, 32'hFFFF_FFFF, 0, '1, '0, 8'hFF);
        drive_item(OP_QUOTE, 1'b1, 31, 0, 32'hFFFF_FFFF, '0, '1, 8'h00);
        put_quote(0, 0, 32'hFFFF_FFFF);
        drop_book();
        put_quote(3, 5, 100);
        put_quote(1, 6, 32'hFFFF_FFFF);
        put_quote(3, 5, 32'hFFFF_FFFF);
        put_quote(1, 2, 32'hFFFF_FFFF);
        drop_book();
        drive_item(OP_QUOTE, 1'b1, 31, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '1, '1, 8'hFF);
        drive_item(OP_CLEAR, 1'b0, 0, 0, 0, 0, 0, 0);

        // random part, with a stretch where neither side idles
        effective = 0;
        while (effective < RANDOM_ITEMS) begin
            calm = (effective >= 500) && (effective < 700);
            r = $urandom_range(99);
            if (r < 3) begin
                drop_book();
                effective++;
            end else if (r < 12) begin
                drive_item(OP_QUOTE, 1'b0, EXCH_W'($urandom_range(31)), $urandom, $urandom,
                           $urandom, $urandom, COND_W'($urandom_range(255)));
                effective++;
            end else begin
                put_quote(pick_exchange(), pick_price(), pick_price());
                effective++;
            end
        end
        calm = 1'b0;
        s_tvalid <= 1'b0;

        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("run: %0d transactions in (%0d clears, %0d ineligible), %0d results compared",
                 sent, clears, ignored, checked);
        $display("run: %0d best holder rescans exercised", rescans);
        if (fail_count == 0 && pending == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule
